// File: design/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned TAB_STEP   = 3;
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;

  localparam logic [0:0]  REG_TEXT_ATTR = 1'b0;

  typedef enum logic {
    REQ_PUT  = 1'b0,
    REQ_READ = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_ACCESS,
    ST_FILL,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [7:0]         char_code;
    logic [POS_W-1:0]   cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   cursor_pos;
    logic [7:0]         cell_char;
    logic [7:0]         cell_attr;
  } tcw_rsp_t;

endpackage

// File: design/tcw_screen_ram.sv
// Screen cell memory: one write port, one registered read port.
module tcw_screen_ram #(
  parameter int unsigned CELLS = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [CELLS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tcw_apb_regs.sv
// APB configuration register holding the text attribute.
module tcw_apb_regs
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [7:0]         text_attr_o
);

  logic [7:0] attr_q;
  logic [7:0] attr_d;
  logic       hit;

  assign hit = (paddr[PADDR_W-1] == REG_TEXT_ATTR);

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && pready && hit) begin
      attr_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign pready      = 1'b1;
  assign prdata      = hit ? {{(PDATA_W-8){1'b0}}, attr_q} : '0;
  assign text_attr_o = attr_q;

endmodule

// File: design/tcw_engine.sv
// Request sequencer: cursor tracking, scroll ring and screen memory access.
module tcw_engine
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  parameter int unsigned CELLS   = 2000,
  parameter int unsigned AW      = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tcw_req_t      req_i,
  output logic          rsp_valid_o,
  output tcw_rsp_t      rsp_o,
  input  logic [7:0]    text_attr_i,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [15:0]   ram_wdata_o,
  output logic          ram_re_o,
  output logic [AW-1:0] ram_raddr_o,
  input  logic [15:0]   ram_rdata_i
);

  localparam int unsigned CW  = $clog2(COLUMNS);
  localparam int unsigned RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IW  = POS_W;
  localparam int unsigned SW  = ((AW > IW) ? AW : IW) + 1;
  localparam int unsigned XW  = CW + 2;

  tcw_state_e    state_q, state_d;
  tcw_req_t      req_q, req_d;
  logic [AW-1:0] phys_q, phys_d;
  logic          in_range_q, in_range_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] row_base_q, row_base_d;
  logic [AW-1:0] top_base_q, top_base_d;
  logic [AW-1:0] fill_base_q, fill_base_d;
  logic [AW-1:0] cnt_q, cnt_d;

  logic [SW-1:0] sum_base;
  logic [SW-1:0] phys_sum;
  logic [SW-1:0] phys_wrap;
  logic [SW-1:0] top_nxt;
  logic [SW-1:0] pos_sum;
  logic [XW-1:0] col_inc;
  logic          newline;
  logic          is_read;

  assign is_read  = (req_q.req_type == REQ_READ);
  assign sum_base = is_read ? SW'(req_q.cell_index) : (SW'(row_base_q) + SW'(col_q));
  assign phys_sum = sum_base + SW'(top_base_q);
  assign phys_wrap = (phys_sum >= SW'(CELLS)) ? (phys_sum - SW'(CELLS)) : phys_sum;
  assign top_nxt  = ((SW'(top_base_q) + SW'(COLUMNS)) >= SW'(CELLS)) ?
                    '0 : (SW'(top_base_q) + SW'(COLUMNS));
  assign col_inc  = XW'(col_q) + ((req_q.char_code == CHAR_TAB) ? XW'(TAB_STEP) : XW'(1));
  assign pos_sum  = SW'(row_base_q) + SW'(col_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    phys_d      = phys_q;
    in_range_d  = in_range_q;
    col_d       = col_q;
    row_d       = row_q;
    row_base_d  = row_base_q;
    top_base_d  = top_base_q;
    fill_base_d = fill_base_q;
    cnt_d       = cnt_q;
    newline     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = phys_q;
    ram_wdata_o = {text_attr_i, req_q.char_code};
    ram_re_o    = 1'b0;
    ram_raddr_o = phys_q;
    rsp_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = {ATTR_RESET, 8'h00};
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        phys_d     = phys_wrap[AW-1:0];
        in_range_d = (SW'(req_q.cell_index) < SW'(CELLS));
        state_d    = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_d = ST_DONE;
        if (is_read) begin
          ram_re_o = in_range_q;
        end else begin
          if (req_q.char_code == CHAR_LF || req_q.char_code == CHAR_CR) begin
            newline = 1'b1;
          end else begin
            ram_we_o = (req_q.char_code != CHAR_TAB);
            if (col_inc >= XW'(COLUMNS)) begin
              newline = 1'b1;
            end else begin
              col_d = col_inc[CW-1:0];
            end
          end
          if (newline) begin
            col_d = '0;
            if (row_q == RW'(ROWS - 1)) begin
              fill_base_d = top_base_q;
              top_base_d  = top_nxt[AW-1:0];
              cnt_d       = '0;
              state_d     = ST_FILL;
            end else begin
              row_d      = row_q + RW'(1);
              row_base_d = row_base_q + AW'(COLUMNS);
            end
          end
        end
      end
      ST_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = fill_base_q + cnt_q;
        ram_wdata_o = {text_attr_i, 8'h00};
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == AW'(COLUMNS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        rsp_valid_o = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      top_base_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      top_base_q <= top_base_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    phys_q      <= phys_d;
    in_range_q  <= in_range_d;
    fill_base_q <= fill_base_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign rsp_o.cursor_pos = pos_sum[POS_W-1:0];
  assign rsp_o.cell_char  = (is_read && in_range_q) ? ram_rdata_i[7:0]  : 8'h00;
  assign rsp_o.cell_attr  = (is_read && in_range_q) ? ram_rdata_i[15:8] : 8'h00;

`ifndef SYNTHESIS
  a_rsp_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !busy_o)
    else $error("result transfer not followed by idle");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !rsp_valid_o))
    else $error("accepted request did not start work");

  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((XW'(col_q) < XW'(COLUMNS)) &&
                              (SW'(row_base_q) == SW'(row_q) * SW'(COLUMNS))))
    else $error("cursor column or row base out of step");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_CLEAR || state_q == ST_ACCESS || state_q == ST_FILL))
    else $error("screen write outside a write state");

  a_read_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("screen read and write in the same cycle");
`endif

endmodule

// File: design/text_console_writer.sv
// Top level of the text console writer.
// After reset the block holds busy high while it sweeps the screen memory to blanks with
// attribute 7. A put or read request then steps from one accepted start to the next through
// setting up the address, one access to the screen memory, the result, and an idle state
// with busy low. The result strobe rises in the DONE state, which follows the ADDR and ACCESS
// states (and FILL on a scroll) after the edge that takes start, and lasts one cycle; it cannot
// be held off. A put that scrolls the screen writes a blank bottom row, one cell per cycle,
// before its result. The screen is a ring of rows, so a scroll moves no stored cells.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tcw_req_t           req_i,
  output logic               rsp_valid_o,
  output tcw_rsp_t           rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [7:0]    text_attr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  tcw_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .text_attr_o (text_attr)
  );

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .AW      (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .text_attr_i (text_attr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_screen_ram #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: dv/text_console_writer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the text console writer against a local screen image.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned NUM_COLS   = 80;
  localparam int unsigned NUM_ROWS   = 25;
  localparam int unsigned NUM_CELLS  = NUM_COLS * NUM_ROWS;
  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned LIMIT_CYC  = 400000;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'({REG_TEXT_ATTR, 2'b00});

  typedef enum int {
    SEG_SHORT_LINE,
    SEG_EDGE_TAB,
    SEG_WRAP_LINE,
    SEG_BLANK_LINES,
    SEG_READS,
    SEG_NOISE
  } seg_kind_e;

  logic               clk_i;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  tcw_req_t           req_i   = '0;
  logic               rsp_valid_o;
  tcw_rsp_t           rsp_o;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tcw_req_t   char_req_q[$];
  tcw_rsp_t   due_rsp_q[$];

  logic [15:0] screen_img[NUM_CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  attr_shadow;

  logic        xfer_seen;
  int unsigned gap_left;
  int unsigned burst_left;

  int unsigned err_cnt   = 0;
  int unsigned gen_cnt   = 0;
  int unsigned n_put     = 0;
  int unsigned n_read    = 0;
  int unsigned n_oor     = 0;
  int unsigned n_scroll  = 0;
  int unsigned n_wrap    = 0;
  int unsigned n_tabwrap = 0;
  int unsigned n_attr    = 1;

  text_console_writer #(
    .COLUMNS(NUM_COLS),
    .ROWS   (NUM_ROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_HALF);
    clk_i = 1'b0;
    #(CLK_HALF);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < 40) begin
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= NUM_ROWS) begin
      for (int k = 0; k < (NUM_ROWS - 1) * NUM_COLS; k++) begin
        screen_img[k] = screen_img[k + NUM_COLS];
      end
      for (int k = 0; k < NUM_COLS; k++) begin
        screen_img[(NUM_ROWS - 1) * NUM_COLS + k] = {attr_shadow, 8'h00};
      end
      cur_row = NUM_ROWS - 1;
      n_scroll++;
    end
  endfunction

  function automatic tcw_rsp_t console_step(input tcw_req_t r);
    tcw_rsp_t o;
    o = '0;
    if (r.req_type == REQ_PUT) begin
      n_put++;
      if (r.char_code == CHAR_TAB) begin
        cur_col += TAB_STEP;
        if (cur_col >= NUM_COLS) begin
          n_tabwrap++;
          line_feed();
        end
      end else if (r.char_code == CHAR_LF || r.char_code == CHAR_CR) begin
        line_feed();
      end else begin
        screen_img[cur_row * NUM_COLS + cur_col] = {attr_shadow, r.char_code};
        cur_col++;
        if (cur_col >= NUM_COLS) begin
          n_wrap++;
          line_feed();
        end
      end
    end else begin
      n_read++;
      if (r.cell_index < NUM_CELLS) begin
        o.cell_char = screen_img[r.cell_index][7:0];
        o.cell_attr = screen_img[r.cell_index][15:8];
      end else begin
        n_oor++;
      end
    end
    o.cursor_pos = POS_W'(cur_row * NUM_COLS + cur_col);
    return o;
  endfunction

  // Driver: present one request per transfer, bursts separated by random gaps.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      gap_left   <= 0;
      burst_left <= 1;
    end else if (!start || xfer_seen) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (char_req_q.size() != 0) begin
        req_i <= char_req_q.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 11);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result strobe, then predict any request taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin : mon
    tcw_rsp_t want;
    if (!rst_ni) begin
      xfer_seen <= 1'b0;
    end else begin
      xfer_seen <= start && !busy;
      if (rsp_valid_o === 1'b1) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("result with none due", 32'(rsp_o), 0);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_o.cursor_pos !== want.cursor_pos)
            report_mismatch("cursor_pos", 32'(rsp_o.cursor_pos), 32'(want.cursor_pos));
          if (rsp_o.cell_char !== want.cell_char)
            report_mismatch("cell_char", 32'(rsp_o.cell_char), 32'(want.cell_char));
          if (rsp_o.cell_attr !== want.cell_attr)
            report_mismatch("cell_attr", 32'(rsp_o.cell_attr), 32'(want.cell_attr));
        end
      end
      if (start && !busy) begin
        due_rsp_q.push_back(console_step(req_i));
      end
    end
  end

  task automatic apb_write(input logic [7:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ATTR_ADDR;
    pwdata  = PDATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check(input logic [7:0] val);
    logic [PDATA_W-1:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ATTR_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== PDATA_W'(val)) report_mismatch("text_attr readback", got, 32'(val));
    @(posedge clk_i);
  endtask

  task automatic queue_put(input logic [7:0] c);
    tcw_req_t r;
    r.req_type   = REQ_PUT;
    r.char_code  = c;
    r.cell_index = POS_W'($urandom_range(0, 2047));
    char_req_q.push_back(r);
    gen_cnt++;
  endtask

  task automatic queue_read(input int unsigned idx);
    tcw_req_t r;
    r.req_type   = REQ_READ;
    r.char_code  = 8'($urandom_range(0, 255));
    r.cell_index = POS_W'(idx);
    char_req_q.push_back(r);
    gen_cnt++;
  endtask

  function automatic logic [7:0] rand_glyph();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  function automatic int unsigned rand_cell();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, NUM_CELLS - 1);
    if (r < 9) return $urandom_range((NUM_ROWS - 1) * NUM_COLS, NUM_CELLS - 1);
    return $urandom_range(NUM_CELLS, 2047);
  endfunction

  task automatic queue_segment();
    seg_kind_e   seg;
    int unsigned r;
    int unsigned len;
    tcw_req_t    q;
    r = $urandom_range(0, 99);
    if (r < 30)      seg = SEG_SHORT_LINE;
    else if (r < 42) seg = SEG_EDGE_TAB;
    else if (r < 50) seg = SEG_WRAP_LINE;
    else if (r < 62) seg = SEG_BLANK_LINES;
    else if (r < 85) seg = SEG_READS;
    else             seg = SEG_NOISE;
    case (seg)
      SEG_SHORT_LINE: begin
        len = $urandom_range(0, 20);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) queue_put(CHAR_TAB);
          else queue_put(rand_glyph());
        end
        queue_put($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
      end
      SEG_EDGE_TAB: begin
        queue_put(CHAR_CR);
        len = $urandom_range(NUM_COLS - 6, NUM_COLS - 1);
        repeat (len) queue_put(rand_glyph());
        repeat ($urandom_range(1, 2)) queue_put(CHAR_TAB);
      end
      SEG_WRAP_LINE: begin
        len = $urandom_range(NUM_COLS - 2, NUM_COLS + 15);
        repeat (len) queue_put(rand_glyph());
      end
      SEG_BLANK_LINES: begin
        repeat ($urandom_range(1, 6)) queue_put($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
      end
      SEG_READS: begin
        repeat ($urandom_range(1, 8)) queue_read(rand_cell());
      end
      default: begin
        repeat ($urandom_range(1, 10)) begin
          q.req_type   = req_type_e'($urandom_range(0, 1));
          q.char_code  = 8'($urandom_range(0, 255));
          q.cell_index = POS_W'($urandom_range(0, 2047));
          char_req_q.push_back(q);
          gen_cnt++;
        end
      end
    endcase
  endtask

  task automatic wait_quiet();
    while (char_req_q.size() != 0 || start || due_rsp_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    #(CLK_HALF * 2 * LIMIT_CYC);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : seq
    logic [7:0]  attr_set[4];
    int unsigned mark;
    attr_set = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), ATTR_RESET};
    attr_shadow = ATTR_RESET;
    cur_col = 0;
    cur_row = 0;
    foreach (screen_img[k]) screen_img[k] = {ATTR_RESET, 8'h00};

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apb_check(ATTR_RESET);

    queue_read(0);
    queue_read(NUM_CELLS - 1);
    queue_read(NUM_CELLS);
    queue_read(2047);
    queue_put(8'h48);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(CHAR_TAB);
    queue_put(8'h80);
    queue_put(8'h7F);
    queue_put(CHAR_CR);
    queue_put(8'h55);
    queue_put(8'hAA);
    queue_put(CHAR_LF);
    queue_put(CHAR_TAB);
    queue_put(CHAR_TAB);
    queue_put(8'h01);
    queue_read(0);
    queue_read(2);
    queue_read(4);
    queue_read(6);
    queue_read(NUM_COLS + 1);
    queue_read(2 * NUM_COLS + 6);
    wait_quiet();

    foreach (attr_set[p]) begin
      apb_write(attr_set[p]);
      attr_shadow = attr_set[p];
      n_attr++;
      apb_check(attr_set[p]);
      mark = gen_cnt;
      while (gen_cnt - mark < PHASE_ITEMS) queue_segment();
      wait_quiet();
    end

    repeat (NUM_COLS + 8) @(posedge clk_i);
    if (due_rsp_q.size() != 0) report_mismatch("results never seen", due_rsp_q.size(), 0);
    $display("Covered %0d transfers: %0d puts, %0d reads (%0d outside the screen), %0d attributes",
             n_put + n_read, n_put, n_read, n_oor, n_attr);
    $display("Cursor motion: %0d scrolls, %0d line wraps, %0d tab wraps, %0d mismatches",
             n_scroll, n_wrap, n_tabwrap, err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
